// ----- hdl/bwdi_pkg.sv -----
// ----------------------------------------------------------------------------
// bwdi_pkg: shared types and constants of the bob/weave deinterlacer
// Beat layouts, internal stage payloads, register indexes and line sizing.
// ----------------------------------------------------------------------------
package bwdi_pkg;

  // Line store depth and derived widths
  localparam int LINE_MAX   = 1024;
  localparam int ADDR_W     = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int LEN_W      = ADDR_W + 1;
  localparam int LP_W       = 11;
  localparam int LEN_CMP_W  = (LEN_W > LP_W) ? LEN_W : LP_W;

  // Register widths
  localparam int EDGE_W     = 14;
  localparam int THR_W      = 13;
  localparam int CFG_DATA_W = 14;
  localparam int CFG_IDX_W  = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_DETECT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JAGGIE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PIXELS      = 2'd2;

  // Register reset values
  localparam logic [EDGE_W-1:0] EDGE_DETECT_RST      = 14'd625;
  localparam logic [THR_W-1:0]  JAGGIE_THRESHOLD_RST = 13'd73;
  localparam logic [LP_W-1:0]   LINE_PIXELS_RST      = 11'd720;

  // Squared difference is taken down by this many bits
  localparam int SQ_SHIFT = 12;

  typedef struct packed {
    logic       field_start;
    logic [7:0] cur_luma;
    logic [7:0] cur_chroma;
    logic [7:0] opp_luma;
    logic [7:0] opp_chroma;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_luma;
    logic [7:0] out_chroma;
    logic       rebuilt_line;
    logic       final_of_run;
  } out_beat_t;

  typedef struct packed {
    logic [EDGE_W-1:0] edge_detect;
    logic [THR_W-1:0]  jaggie_threshold;
    logic [LP_W-1:0]   line_pixels;
  } cfg_t;

  // Front stage payload
  typedef struct packed {
    logic       first;
    logic [7:0] cur_y;
    logic [7:0] cur_c;
    logic [7:0] opp_y;
    logic [7:0] opp_c;
  } s1_t;

  // Payload carried through the metric stages
  typedef struct packed {
    logic       first;
    logic [7:0] cur_y;
    logic [7:0] cur_c;
    logic [7:0] opp_y;
    logic [7:0] opp_c;
    logic [7:0] avg_y;
    logic [7:0] avg_c;
  } pix_t;

  // Finished item handed to the beat sequencer
  typedef struct packed {
    logic       first;
    logic [7:0] rb_y;
    logic [7:0] rb_c;
    logic [7:0] cur_y;
    logic [7:0] cur_c;
  } item_t;

endpackage

// ----- hdl/bob_weave_deinterlace_pixel.sv -----
// ----------------------------------------------------------------------------
// bob_weave_deinterlace_pixel: bob/weave deinterlacer for YUYV pixel streams
// Top level: configuration registers, front end, metric pipeline and beat
// sequencer.
// ----------------------------------------------------------------------------
// Each input beat carries one current-field pixel half and the opposite-field
// pixel half of the missing line just above it. On the first line of a field
// the current pixel comes out alone. On later lines two beats come out: the
// rebuilt missing-line pixel (rounded average of the stored line above and
// the current pixel when the jaggie metric beats the threshold, otherwise the
// weave pixel), then the current pixel. Input beats are taken only while the
// pipeline advances; unless the output stalls, the port moves one beat per
// cycle, so the first line runs at one item per cycle, while later lines
// send two beats per item and the sequencer holds the input during the
// rebuilt beat. An item passes the line store read, then three metric stages,
// then the output register. When the output stalls, the whole pipeline holds.
// The line store needs no clearing after reset: an entry is used only after
// the previous line wrote it. Write the registers only while the block is idle.
// ----------------------------------------------------------------------------
module bob_weave_deinterlace_pixel import bwdi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg;
  logic        adv;
  logic        s1_valid;
  s1_t         s1;
  logic [15:0] above;
  logic        item_valid;
  item_t       item;

  // Register file; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_detect      <= EDGE_DETECT_RST;
      cfg.jaggie_threshold <= JAGGIE_THRESHOLD_RST;
      cfg.line_pixels      <= LINE_PIXELS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EDGE_DETECT:      cfg.edge_detect      <= cfg_data[EDGE_W-1:0];
        CFG_JAGGIE_THRESHOLD: cfg.jaggie_threshold <= cfg_data[THR_W-1:0];
        CFG_LINE_PIXELS:      cfg.line_pixels      <= cfg_data[LP_W-1:0];
        default: ;
      endcase
    end
  end

  // Every stage advances together; hold them all while the output waits
  assign in_ready = adv;

  bwdi_front u_front (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .line_pixels (cfg.line_pixels),
    .s1_valid    (s1_valid),
    .s1          (s1),
    .above       (above)
  );

  bwdi_metric u_metric (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .cfg        (cfg),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .above      (above),
    .item_valid (item_valid),
    .item       (item)
  );

  bwdi_out u_out (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .adv        (adv),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ----- hdl/bwdi_front.sv -----
// ----------------------------------------------------------------------------
// bwdi_front: column tracking and line store
// Counts columns, flags the first line of a field, reads the pixel above and
// writes the current pixel back to the same column.
// ----------------------------------------------------------------------------
module bwdi_front import bwdi_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  in_beat_t        in_data,
  input  logic [LP_W-1:0] line_pixels,
  output logic            s1_valid,
  output s1_t             s1,
  output logic [15:0]     above
);

  logic [ADDR_W-1:0]    column_count;
  logic                 first_line_flag;
  logic [ADDR_W-1:0]    col;
  logic                 first_eff;
  logic [LEN_CMP_W-1:0] lp_ext;
  logic [LEN_CMP_W-1:0] len;
  logic [LEN_CMP_W-1:0] col_inc;
  logic                 wrap;
  logic                 accept;

  logic [15:0] line_store [LINE_MAX];

  always_comb begin
    col       = in_data.field_start ? '0 : column_count;
    first_eff = in_data.field_start | first_line_flag;
    lp_ext    = LEN_CMP_W'(line_pixels);
    if (lp_ext == '0) begin
      len = LEN_CMP_W'(1);
    end else if (lp_ext > LEN_CMP_W'(LINE_MAX)) begin
      len = LEN_CMP_W'(LINE_MAX);
    end else begin
      len = lp_ext;
    end
    col_inc = LEN_CMP_W'(col) + LEN_CMP_W'(1);
    wrap    = (col_inc >= len);
    accept  = adv & in_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      first_line_flag <= 1'b1;
    end else if (accept) begin
      if (wrap) begin
        column_count    <= '0;
        first_line_flag <= 1'b0;
      end else begin
        column_count    <= col_inc[ADDR_W-1:0];
        first_line_flag <= first_eff;
      end
    end
  end

  // Read returns the old entry; the write lands for the next line
  always_ff @(posedge clk) begin
    if (accept) begin
      line_store[col] <= {in_data.cur_luma, in_data.cur_chroma};
    end
    if (adv) begin
      above <= line_store[col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1.first <= first_eff;
      s1.cur_y <= in_data.cur_luma;
      s1.cur_c <= in_data.cur_chroma;
      s1.opp_y <= in_data.opp_luma;
      s1.opp_c <= in_data.opp_chroma;
    end
  end

endmodule

// ----- hdl/bwdi_metric.sv -----
// ----------------------------------------------------------------------------
// bwdi_metric: jaggie metric pipeline
// Differences, products and threshold compare over three register stages;
// picks the rounded average or the weave pixel for the rebuilt line.
// ----------------------------------------------------------------------------
module bwdi_metric import bwdi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  cfg_t        cfg,
  input  logic        s1_valid,
  input  s1_t         s1,
  input  logic [15:0] above,
  output logic        item_valid,
  output item_t       item
);

  // Stage 2: halved-luma differences and averages
  logic              s2_valid;
  pix_t              s2;
  logic signed [7:0] s2_da;
  logic signed [7:0] s2_db;
  logic signed [7:0] s2_dd;

  // Stage 3: products
  logic               s3_valid;
  pix_t               s3;
  logic signed [15:0] s3_p;
  logic [1:0]         s3_sq;

  // Stage 4: weighted square
  logic               s4_valid;
  pix_t               s4;
  logic signed [15:0] s4_p;
  logic [15:0]        s4_w;

  logic [7:0]         ay;
  logic [7:0]         ac;
  logic signed [7:0]  ha;
  logic signed [7:0]  he;
  logic signed [7:0]  hb;
  logic [8:0]         sum_y;
  logic [8:0]         sum_c;
  logic signed [15:0] dsq;
  logic signed [15:0] m;
  logic signed [16:0] m_ext;
  logic signed [16:0] thr_ext;
  logic               take_avg;

  always_comb begin
    ay    = above[15:8];
    ac    = above[7:0];
    ha    = signed'({1'b0, ay[7:1]});
    he    = signed'({1'b0, s1.opp_y[7:1]});
    hb    = signed'({1'b0, s1.cur_y[7:1]});
    sum_y = 9'(ay) + 9'(s1.cur_y) + 9'd1;
    sum_c = 9'(ac) + 9'(s1.cur_c) + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2.first <= s1.first;
      s2.cur_y <= s1.cur_y;
      s2.cur_c <= s1.cur_c;
      s2.opp_y <= s1.opp_y;
      s2.opp_c <= s1.opp_c;
      s2.avg_y <= sum_y[8:1];
      s2.avg_c <= sum_c[8:1];
      s2_da    <= ha - he;
      s2_db    <= hb - he;
      s2_dd    <= ha - hb;
    end
  end

  // Halved-luma differences fit 8 bits, so the 16-bit products are exact
  assign dsq = 16'(s2_dd * s2_dd);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3    <= s2;
      s3_p  <= 16'(s2_da * s2_db);
      s3_sq <= dsq[SQ_SHIFT+1:SQ_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4   <= s3;
      s4_p <= s3_p;
      s4_w <= 16'(s3_sq * cfg.edge_detect);
    end
  end

  always_comb begin
    m        = s4_p - signed'(s4_w);
    m_ext    = {m[15], m};
    thr_ext  = signed'({4'b0, cfg.jaggie_threshold});
    take_avg = (m_ext > thr_ext);

    item_valid = s4_valid;
    item.first = s4.first;
    item.rb_y  = take_avg ? s4.avg_y : s4.opp_y;
    item.rb_c  = take_avg ? s4.avg_c : s4.opp_c;
    item.cur_y = s4.cur_y;
    item.cur_c = s4.cur_c;
  end

endmodule

// ----- hdl/bwdi_out.sv -----
// ----------------------------------------------------------------------------
// bwdi_out: result beat sequencer
// Holds one finished item and sends its one or two result beats; releases
// the pipeline when the final beat is taken.
// ----------------------------------------------------------------------------
module bwdi_out import bwdi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  item_t     item,
  output logic      adv,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic  held_valid;
  item_t held;
  logic  phase;
  logic  beat_rb;
  logic  done;

  always_comb begin
    beat_rb   = ~held.first & ~phase;
    done      = held_valid & out_ready & ~beat_rb;
    adv       = ~held_valid | done;
    out_valid = held_valid;
    if (beat_rb) begin
      out_data.out_luma     = held.rb_y;
      out_data.out_chroma   = held.rb_c;
      out_data.rebuilt_line = 1'b1;
      out_data.final_of_run = 1'b0;
    end else begin
      out_data.out_luma     = held.cur_y;
      out_data.out_chroma   = held.cur_c;
      out_data.rebuilt_line = 1'b0;
      out_data.final_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      phase      <= 1'b0;
    end else if (adv) begin
      held_valid <= item_valid;
      phase      <= 1'b0;
    end else if (out_ready & beat_rb) begin
      phase      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      held <= item;
    end
  end

endmodule

// ----- hdl/bwdi_checker.sv -----
// ----------------------------------------------------------------------------
// bwdi_checker: port-level checks of the deinterlacer
// Watches reset, output pairing and back-pressure at the top-level ports.
// ----------------------------------------------------------------------------
module bwdi_checker import bwdi_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A rebuilt beat is followed at once by its original pixel
  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.final_of_run |->
      out_data.rebuilt_line ##1
      (out_valid && !out_data.rebuilt_line && out_data.final_of_run))
    else $error("rebuilt beat not followed by original pixel");

  // Output back-pressure stalls the input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

bind bob_weave_deinterlace_pixel bwdi_checker u_bwdi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
